[sv/qva_pkg.sv]
// Shared types and constants for the quadtree vertex activation block.
// Used by qva_parent and quadtree_vertex_activation; no dependencies of its own.
package qva_pkg;

  localparam int COORD_W = 7;
  localparam int COUNT_W = 13;

  localparam int GRID_SIZE_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 8192;

  typedef enum logic [1:0] {
    OP_ACTIVATE = 2'd0,
    OP_QUERY    = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
  } in_t;

  typedef struct packed {
    logic               was_active;
    logic [COUNT_W-1:0] newly_marked;
    logic               out_of_range;
  } out_t;

  // Stack entry layout: y in the upper bits, x in the lower bits.
  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic ok;
    vtx_t v;
  } cand_t;

  // p_a is pushed first, so p_b is worked first.
  typedef struct packed {
    cand_t p_a;
    cand_t p_b;
  } parents_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_PUSH2,
    ST_POP,
    ST_LOAD,
    ST_RESULT
  } state_t;

endpackage

[sv/qva_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module qva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/qva_parent.sv]
// Parent selection for one vertex: levels, direction choice and grid bounds.
// Depends on qva_pkg (vtx_t, parents_t).
module qva_parent #(
  parameter int GRID_SIZE = qva_pkg::GRID_SIZE_DEF
) (
  input  qva_pkg::vtx_t     cur,
  output qva_pkg::parents_t par
);

  localparam int LW = qva_pkg::COORD_W + 1;

  function automatic logic [LW-1:0] level_of(input logic [qva_pkg::COORD_W-1:0] v);
    logic [qva_pkg::COORD_W-1:0] low;
    low = v & (~v + 1'b1);
    if (v == '0 || {1'b0, v} >= LW'(GRID_SIZE)) begin
      level_of = LW'(GRID_SIZE);
    end else begin
      level_of = {1'b0, low};
    end
  endfunction

  logic [LW-1:0] lx, ly, l, l2;
  logic [LW-1:0] xw, yw, xp, xm, yp, ym;
  logic          ok_xp, ok_xm, ok_yp, ok_ym;

  always_comb begin
    lx = level_of(cur.x);
    ly = level_of(cur.y);
    l  = (lx < ly) ? lx : ly;
    l2 = l << 1;
    xw = {1'b0, cur.x};
    yw = {1'b0, cur.y};
    xp = xw + l;
    xm = xw - l;
    yp = yw + l;
    ym = yw - l;
    ok_xp = xp <= LW'(GRID_SIZE);
    ok_yp = yp <= LW'(GRID_SIZE);
    ok_xm = l <= xw;
    ok_ym = l <= yw;

    if (lx > ly) begin
      par.p_a = '{ok: ok_xp, v: '{y: cur.y, x: xp[LW-2:0]}};
      par.p_b = '{ok: ok_xm, v: '{y: cur.y, x: xm[LW-2:0]}};
    end else if (lx < ly) begin
      par.p_a = '{ok: ok_ym, v: '{y: ym[LW-2:0], x: cur.x}};
      par.p_b = '{ok: ok_yp, v: '{y: yp[LW-2:0], x: cur.x}};
    end else if ((xw & l2) == (yw & l2)) begin
      par.p_a = '{ok: ok_xp && ok_ym, v: '{y: ym[LW-2:0], x: xp[LW-2:0]}};
      par.p_b = '{ok: ok_xm && ok_yp, v: '{y: yp[LW-2:0], x: xm[LW-2:0]}};
    end else begin
      par.p_a = '{ok: ok_xm && ok_ym, v: '{y: ym[LW-2:0], x: xm[LW-2:0]}};
      par.p_b = '{ok: ok_xp && ok_yp, v: '{y: yp[LW-2:0], x: xp[LW-2:0]}};
    end
  end

endmodule

[sv/quadtree_vertex_activation.sv]
// Quadtree vertex activation map: one bit per grid vertex, with parent closure.
// Channels: in_data (opcode, x_coord, y_coord) on in_valid/in_ready, one result
// beat per item on out_data via out_valid/out_ready (registered output).
// Activate marks a vertex and walks its parent chains through a work stack
// held in RAM; query returns the map bit; clear zeroes the map.
// One item is worked at a time; clear wipes the map one entry per cycle.
// A new item is accepted while a finished result still waits in the output
// register; a stalled receiver holds the next result in the sequencer until the
// output register frees up, and in_ready stays low meanwhile.
// After reset the map RAM is swept to zero, one entry a cycle; in_ready is low
// during the sweep. The stack needs no clearing: entries are always written
// before they are read.
// Depends on qva_pkg, qva_ram, qva_parent.
module quadtree_vertex_activation #(
  parameter int GRID_SIZE   = qva_pkg::GRID_SIZE_DEF,
  parameter int STACK_DEPTH = qva_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qva_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qva_pkg::out_t out_data
);

  localparam int SIDE      = GRID_SIZE + 1;
  localparam int MAP_DEPTH = SIDE * SIDE;
  localparam int MAW       = $clog2(MAP_DEPTH);
  localparam int SAW       = $clog2(STACK_DEPTH);
  localparam int SPW       = $clog2(STACK_DEPTH + 1);
  localparam int CW        = qva_pkg::COORD_W;
  localparam int PW        = 2 * CW;
  localparam int VW        = $bits(qva_pkg::vtx_t);

  function automatic logic [MAW-1:0] map_addr(input qva_pkg::vtx_t v);
    logic [PW-1:0] t;
    t = PW'(v.y) * PW'(SIDE) + PW'(v.x);
    map_addr = t[MAW-1:0];
  endfunction

  qva_pkg::state_t   state, state_next;
  qva_pkg::in_t      req;
  qva_pkg::vtx_t     cur;
  qva_pkg::parents_t par;
  logic [qva_pkg::COUNT_W-1:0] count;
  logic              was_set;
  logic              oor;
  logic [SPW-1:0]    sp;
  logic [SPW-1:0]    sp_dec;
  logic [MAW-1:0]    wipe_addr;
  logic              wipe_reply;
  logic              in_range;
  logic              accept;
  qva_pkg::vtx_t     in_vtx;

  // map RAM controls
  logic           map_we, map_wd, map_re, map_rd;
  logic [MAW-1:0] map_wa, map_ra;
  // stack RAM controls
  logic           stk_we, stk_re;
  logic [SAW-1:0] stk_wa, stk_ra;
  qva_pkg::vtx_t  stk_wd, stk_rd;
  logic           push_a_ok, push_b_ok;

  assign in_vtx   = '{y: in_data.y_coord, x: in_data.x_coord};
  assign accept   = in_valid && in_ready;
  assign in_range = (req.x_coord <= CW'(GRID_SIZE)) && (req.y_coord <= CW'(GRID_SIZE));
  assign sp_dec   = sp - 1'b1;
  assign push_a_ok = par.p_a.ok && (sp < SPW'(STACK_DEPTH));
  assign push_b_ok = par.p_b.ok && (sp < SPW'(STACK_DEPTH));

  qva_parent #(
    .GRID_SIZE(GRID_SIZE)
  ) u_parent (
    .cur(cur),
    .par(par)
  );

  qva_ram #(
    .WIDTH(1),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk    (clk),
    .wr_en  (map_we),
    .wr_addr(map_wa),
    .wr_data(map_wd),
    .rd_en  (map_re),
    .rd_addr(map_ra),
    .rd_data(map_rd)
  );

  qva_ram #(
    .WIDTH(VW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_wa),
    .wr_data(stk_wd),
    .rd_en  (stk_re),
    .rd_addr(stk_ra),
    .rd_data(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qva_pkg::ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    map_we     = 1'b0;
    map_wa     = map_addr(cur);
    map_wd     = 1'b0;
    map_re     = 1'b0;
    map_ra     = map_addr(in_vtx);
    stk_we     = 1'b0;
    stk_wa     = sp[SAW-1:0];
    stk_wd     = par.p_a.v;
    stk_re     = 1'b0;
    stk_ra     = sp_dec[SAW-1:0];

    case (state)
      qva_pkg::ST_WIPE: begin
        map_we = 1'b1;
        map_wa = wipe_addr;
        if (wipe_addr == MAW'(MAP_DEPTH - 1)) begin
          state_next = wipe_reply ? qva_pkg::ST_RESULT : qva_pkg::ST_IDLE;
        end
      end
      qva_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        map_re   = 1'b1;
        if (in_valid) begin
          state_next = qva_pkg::ST_START;
        end
      end
      qva_pkg::ST_START: begin
        case (req.opcode)
          qva_pkg::OP_ACTIVATE:
            state_next = in_range ? qva_pkg::ST_CHECK : qva_pkg::ST_RESULT;
          qva_pkg::OP_CLEAR:
            state_next = qva_pkg::ST_WIPE;
          default:
            state_next = qva_pkg::ST_RESULT;
        endcase
      end
      qva_pkg::ST_CHECK: begin
        // map_rd holds the bit of cur (read data stays until the next read)
        if (map_rd) begin
          state_next = qva_pkg::ST_POP;
        end else begin
          map_we     = 1'b1;
          map_wd     = 1'b1;
          stk_we     = push_a_ok;
          state_next = qva_pkg::ST_PUSH2;
        end
      end
      qva_pkg::ST_PUSH2: begin
        stk_we     = push_b_ok;
        stk_wd     = par.p_b.v;
        state_next = qva_pkg::ST_POP;
      end
      qva_pkg::ST_POP: begin
        if (sp == '0) begin
          state_next = qva_pkg::ST_RESULT;
        end else begin
          stk_re     = 1'b1;
          state_next = qva_pkg::ST_LOAD;
        end
      end
      qva_pkg::ST_LOAD: begin
        map_re     = 1'b1;
        map_ra     = map_addr(stk_rd);
        state_next = qva_pkg::ST_CHECK;
      end
      qva_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = qva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qva_pkg::ST_IDLE;
      end
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sp         <= '0;
      wipe_addr  <= '0;
      wipe_reply <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == qva_pkg::ST_RESULT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        qva_pkg::ST_WIPE: begin
          wipe_addr <= wipe_addr + 1'b1;
        end
        qva_pkg::ST_IDLE: begin
          sp <= '0;
        end
        qva_pkg::ST_START: begin
          wipe_addr  <= '0;
          wipe_reply <= 1'b1;
        end
        qva_pkg::ST_CHECK: begin
          if (!map_rd && push_a_ok) begin
            sp <= sp + 1'b1;
          end
        end
        qva_pkg::ST_PUSH2: begin
          if (push_b_ok) begin
            sp <= sp + 1'b1;
          end
        end
        qva_pkg::ST_POP: begin
          if (sp != '0) begin
            sp <= sp_dec;
          end
        end
        default: begin
          sp <= sp;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      qva_pkg::ST_IDLE: begin
        if (accept) begin
          req   <= in_data;
          cur   <= in_vtx;
          count <= '0;
        end
      end
      qva_pkg::ST_START: begin
        was_set <= map_rd && in_range;
        oor     <= !in_range;
      end
      qva_pkg::ST_CHECK: begin
        if (!map_rd) begin
          count <= count + 1'b1;
        end
      end
      qva_pkg::ST_LOAD: begin
        cur <= stk_rd;
      end
      qva_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_data <= '{was_active: was_set, newly_marked: count, out_of_range: oor};
        end
      end
      default: begin
        count <= count;
      end
    endcase
  end

endmodule

[sim/quadtree_vertex_activation_test.sv]
// Self-checking testbench for quadtree_vertex_activation: random and directed ops, with
// an in-bench predictor of the vertex map and its parent closure. Depends on qva_pkg and the RTL.
module quadtree_vertex_activation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qva_pkg::*;

  localparam int GRID        = GRID_SIZE_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int PHASE_ITEMS = 175;
  localparam int DRAIN_WAIT  = 20;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  in_t         pending_ops[$];
  out_t        expected_beats[$];
  bit          vertex_map [0:GRID][0:GRID];
  bit          in_fire;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned mismatches;
  out_t        want;

  quadtree_vertex_activation u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit on_grid(int x, int y);
    return x >= 0 && x <= GRID && y >= 0 && y <= GRID;
  endfunction

  // Largest power of two dividing v, with the grid edges at the top level.
  function automatic int level_of_coord(int v);
    int lv;
    if (v == 0 || v >= GRID) return GRID;
    lv = 1;
    while ((v & lv) == 0) lv = lv << 1;
    return lv;
  endfunction

  // Mark (x,y) and every coarser vertex it depends on; returns the count newly set.
  function automatic int mark_with_parents(int x, int y);
    int wx[$];
    int wy[$];
    int px[2];
    int py[2];
    int cx, cy, lx, ly, l, count;
    count = 0;
    wx.push_back(x);
    wy.push_back(y);
    while (wx.size() > 0) begin
      cx = wx.pop_back();
      cy = wy.pop_back();
      if (!vertex_map[cx][cy]) begin
        vertex_map[cx][cy] = 1'b1;
        count++;
        lx = level_of_coord(cx);
        ly = level_of_coord(cy);
        l  = (lx < ly) ? lx : ly;
        if (lx > ly) begin
          px[0] = cx + l; py[0] = cy; px[1] = cx - l; py[1] = cy;
        end else if (lx < ly) begin
          px[0] = cx; py[0] = cy - l; px[1] = cx; py[1] = cy + l;
        end else if ((cx & (2 * l)) == (cy & (2 * l))) begin
          px[0] = cx + l; py[0] = cy - l; px[1] = cx - l; py[1] = cy + l;
        end else begin
          px[0] = cx - l; py[0] = cy - l; px[1] = cx + l; py[1] = cy + l;
        end
        for (int k = 0; k < 2; k++) begin
          // a full stack drops the push
          if (on_grid(px[k], py[k]) && wx.size() < STACK_DEPTH_DEF) begin
            wx.push_back(px[k]);
            wy.push_back(py[k]);
          end
        end
      end
    end
    return count;
  endfunction

  function automatic out_t activation_result(in_t item);
    out_t r;
    int   x, y;
    bit   on;
    x  = item.x_coord;
    y  = item.y_coord;
    on = on_grid(x, y);
    r  = '0;
    r.out_of_range = !on;
    if (on) r.was_active = vertex_map[x][y];
    if (item.opcode == OP_ACTIVATE) begin
      if (on) r.newly_marked = COUNT_W'(mark_with_parents(x, y));
    end else if (item.opcode == OP_CLEAR) begin
      foreach (vertex_map[i, j]) vertex_map[i][j] = 1'b0;
    end
    return r;
  endfunction

  task automatic queue_op(op_t op, int x, int y);
    in_t it;
    it.opcode  = op;
    it.x_coord = COORD_W'(x);
    it.y_coord = COORD_W'(y);
    pending_ops.push_back(it);
  endtask

  function automatic in_t random_op();
    in_t         it;
    int unsigned pick;
    pick       = $urandom_range(99);
    it.opcode  = OP_ACTIVATE;
    it.x_coord = COORD_W'($urandom_range(GRID));
    it.y_coord = COORD_W'($urandom_range(GRID));
    if (pick < 52) begin
      it.opcode = OP_ACTIVATE;
    end else if (pick < 77) begin
      it.opcode = OP_QUERY;
    end else if (pick < 86) begin
      // off the grid on one or both axes, any opcode
      it.opcode = op_t'(2'($urandom_range(3)));
      case ($urandom_range(2))
        0: it.x_coord = COORD_W'($urandom_range(127, GRID + 1));
        1: it.y_coord = COORD_W'($urandom_range(127, GRID + 1));
        default: begin
          it.x_coord = COORD_W'($urandom_range(127, GRID + 1));
          it.y_coord = COORD_W'($urandom_range(127, GRID + 1));
        end
      endcase
    end else if (pick < 90) begin
      it.opcode = op_t'(2'd3);
    end else if (pick < 97) begin
      // pin one axis to a grid edge
      it.opcode = OP_ACTIVATE;
      if ($urandom_range(1)) it.x_coord = $urandom_range(1) ? COORD_W'(GRID) : '0;
      else                   it.y_coord = $urandom_range(1) ? COORD_W'(GRID) : '0;
    end else begin
      it.opcode  = OP_CLEAR;
      it.x_coord = COORD_W'($urandom_range(127));
      it.y_coord = COORD_W'($urandom_range(127));
    end
    return it;
  endfunction

  // Driver: a beat leaves the queue only when the previous one was taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on accepted input beats, check accepted output beats.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: was_active=%0d newly_marked=%0d oor=%0d",
                     out_data.was_active, out_data.newly_marked, out_data.out_of_range);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.was_active !== want.was_active ||
              out_data.newly_marked !== want.newly_marked ||
              out_data.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       want.was_active, want.newly_marked, want.out_of_range,
                       out_data.was_active, out_data.newly_marked, out_data.out_of_range);
          end
        end
      end
      if (in_valid && in_ready) expected_beats.push_back(activation_result(in_data));
      in_fire <= in_valid && in_ready;
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    cycle_count   = 0;
    mismatches    = 0;

    // directed: edges, deep chains, revisits, off-grid and the spare opcode
    queue_op(OP_QUERY, 0, 0);
    queue_op(OP_ACTIVATE, 0, 0);
    queue_op(OP_ACTIVATE, GRID, GRID);
    queue_op(OP_ACTIVATE, 32, 32);
    queue_op(OP_ACTIVATE, 1, 1);
    queue_op(OP_ACTIVATE, 1, 1);
    queue_op(OP_ACTIVATE, 63, 0);
    queue_op(OP_ACTIVATE, 0, 63);
    queue_op(OP_ACTIVATE, 33, 31);
    queue_op(OP_ACTIVATE, GRID, 127);
    queue_op(OP_ACTIVATE, 127, 0);
    queue_op(OP_QUERY, GRID + 1, GRID + 1);
    queue_op(OP_QUERY, 127, 127);
    queue_op(OP_QUERY, 1, 1);
    queue_op(op_t'(2'd3), 62, 63);
    queue_op(op_t'(2'd3), 127, 127);
    queue_op(OP_CLEAR, 1, 1);
    queue_op(OP_QUERY, 1, 1);
    queue_op(OP_ACTIVATE, GRID, 1);
    queue_op(OP_CLEAR, 127, 127);
    queue_op(OP_QUERY, GRID, 1);
    queue_op(OP_ACTIVATE, 1, 63);
    queue_op(OP_ACTIVATE, 127, 127);
    queue_op(OP_QUERY, 2, 2);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) pending_ops.push_back(random_op());
      while (pending_ops.size() != 0) @(posedge clk);
    end

    while (in_valid || expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
